FILE: rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP cache with request retry.
// ----------------------------------------------------------------------------
package arpc_pkg;
    localparam int CACHE_ENTRIES_DEF = 16;
    localparam int REQ_SLOTS_DEF     = 8;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_QUEUE  = 2'd2;
    localparam logic [1:0] ACT_TICK   = 2'd3;

    localparam logic [2:0] KIND_LOOKUP = 3'd0;
    localparam logic [2:0] KIND_INSERT = 3'd1;
    localparam logic [2:0] KIND_QUEUED = 3'd2;
    localparam logic [2:0] KIND_SEND   = 3'd3;
    localparam logic [2:0] KIND_UNRCH  = 3'd4;
    localparam logic [2:0] KIND_IDLE   = 3'd5;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_RETRY   = 1'b1;

    // cache entry word: ip, mac, age
    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [15:0] age;
    } entry_t;

    // request slot word
    typedef struct packed {
        logic [31:0] ip;
        logic [7:0]  sends;
        logic [1:0]  since;
        logic [7:0]  pkts;
    } req_t;
endpackage

FILE: rtl/arp_cache_with_request_retry_top.sv
// ----------------------------------------------------------------------------
// arp_cache_with_request_retry_top
// One item at a time; the next beat is taken once the final result is loaded.
// Reset (aresetn low, synchronous) clears valid bits, returns to idle and
// loads the default timeout and retry values; the memories need no clearing
// pass since valid bits live in flip-flops.
// ----------------------------------------------------------------------------
module arp_cache_with_request_retry_top #(
    parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF,
    parameter int REQ_SLOTS     = arpc_pkg::REQ_SLOTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action[1:0]
    input  logic [1:0]   s_tuser,
    // ip_addr[31:0], mac_addr[79:32], has_packet[80], zero pad
    input  logic [87:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // kind[2:0]
    output logic [2:0]   m_tuser,
    // ip_addr_out[31:0], mac_out[79:32], found[80], packet_count[88:81],
    // full_res[89], zero pad
    output logic [95:0]  m_tdata,
    output logic         m_tlast
);
    localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int RW = (REQ_SLOTS > 1) ? $clog2(REQ_SLOTS) : 1;
    localparam logic [CW-1:0] CLAST = CW'(CACHE_ENTRIES - 1);
    localparam logic [RW-1:0] RLAST = RW'(REQ_SLOTS - 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RREQ  = 4'd1; // request scan issue
    localparam logic [3:0] ST_WREQ  = 4'd2; // request scan evaluate
    localparam logic [3:0] ST_RENT  = 4'd3; // cache scan issue
    localparam logic [3:0] ST_WENT  = 4'd4; // cache scan evaluate
    localparam logic [3:0] ST_QRD   = 4'd5; // queue read of chosen slot
    localparam logic [3:0] ST_QWR   = 4'd6;
    localparam logic [3:0] ST_TRD   = 4'd7; // tick request read
    localparam logic [3:0] ST_TWR   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9; // wait for output to drain
    localparam logic [3:0] ST_FIN   = 4'd10;

    logic [15:0] timeout_reg;
    logic [7:0]  retry_reg;
    logic [3:0]  state_reg, state_next;
    logic [1:0]  act_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    logic        pkt_reg;
    logic [CW-1:0] ci_reg;
    logic [RW-1:0] ri_reg;
    logic [CACHE_ENTRIES-1:0] evalid_reg;
    logic [REQ_SLOTS-1:0]     rvalid_reg;
    logic        hit_reg;
    logic [47:0] hmac_reg;
    logic        rfound_reg;
    logic [RW-1:0] rslot_reg;
    logic [7:0]  rpkts_reg;
    logic        anyout_reg;
    logic [2:0]  hkind_reg;
    logic [31:0] hip_reg;
    logic [7:0]  hpkts_reg;
    logic        ovalid_reg;
    logic [95:0] odata_reg;
    logic [2:0]  ouser_reg;
    logic        olast_reg;

    logic        ewe, rwe;
    logic [CW-1:0] ewaddr, eraddr;
    logic [RW-1:0] rwaddr, rraddr;
    arpc_pkg::entry_t ewdata, erdata;
    arpc_pkg::req_t   rwdata, rrdata;

    arpc_ram #(.WIDTH($bits(arpc_pkg::entry_t)), .DEPTH(CACHE_ENTRIES)) u_ent (
        .aclk(aclk), .we(ewe), .waddr(ewaddr), .wdata(ewdata),
        .raddr(eraddr), .rdata(erdata)
    );
    arpc_ram #(.WIDTH($bits(arpc_pkg::req_t)), .DEPTH(REQ_SLOTS)) u_req (
        .aclk(aclk), .we(rwe), .waddr(rwaddr), .wdata(rwdata),
        .raddr(rraddr), .rdata(rrdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;
    assign m_tlast  = olast_reg;

    logic out_free;
    assign out_free = !ovalid_reg || m_tready;

    // free-slot and free-entry searches over valid flip-flops
    logic          efree_any, rfree_any;
    logic [CW-1:0] efree_idx;
    logic [RW-1:0] rfree_idx;
    always_comb begin
        efree_any = 1'b0;
        efree_idx = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
            if (!evalid_reg[i]) begin
                efree_any = 1'b1;
                efree_idx = CW'(i);
            end
        end
        rfree_any = 1'b0;
        rfree_idx = '0;
        for (int i = REQ_SLOTS - 1; i >= 0; i--) begin
            if (!rvalid_reg[i]) begin
                rfree_any = 1'b1;
                rfree_idx = RW'(i);
            end
        end
    end

    function automatic logic [95:0] pack_out(logic [31:0] ip, logic [47:0] mac,
                                             logic fnd, logic [7:0] pk,
                                             logic full);
        pack_out = {6'b000000, full, pk, fnd, mac, ip};
    endfunction

    // tick arithmetic on the request and cache entry read back
    logic [1:0] since_inc;
    logic [15:0] age_inc;
    assign since_inc = (rrdata.since == 2'd3) ? 2'd3 : rrdata.since + 2'd1;
    assign age_inc = (erdata.age == 16'hFFFF) ? erdata.age : erdata.age + 16'd1;

    always_comb begin
        ewe = 1'b0; ewaddr = ci_reg; ewdata = erdata; eraddr = ci_reg;
        rwe = 1'b0; rwaddr = ri_reg; rwdata = rrdata; rraddr = ri_reg;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == arpc_pkg::ACT_LOOKUP) ? ST_RENT :
                                 (s_tuser == arpc_pkg::ACT_TICK) ? ST_RENT :
                                 ST_RREQ;
                end
            end
            ST_RREQ: state_next = ST_WREQ;
            ST_WREQ: begin
                if ((rvalid_reg[ri_reg] && rrdata.ip == ip_reg) || ri_reg == RLAST)
                    state_next = (act_reg == arpc_pkg::ACT_INSERT) ? ST_OUT : ST_QRD;
                else
                    state_next = ST_RREQ;
            end
            ST_RENT: state_next = ST_WENT;
            ST_WENT: begin
                if (act_reg == arpc_pkg::ACT_TICK && evalid_reg[ci_reg]) begin
                    ewe = 1'b1;
                    ewdata.age = age_inc;
                end
                if (ci_reg == CLAST)
                    state_next = (act_reg == arpc_pkg::ACT_TICK) ? ST_TRD : ST_OUT;
                else
                    state_next = ST_RENT;
            end
            ST_QRD: begin
                rraddr = rslot_reg;
                state_next = ST_QWR;
            end
            ST_QWR: begin
                rraddr = rslot_reg;
                state_next = ST_OUT;
            end
            ST_TRD: state_next = ST_TWR;
            ST_TWR: begin
                if (rvalid_reg[ri_reg]) begin
                    rwe = 1'b1;
                    rwdata.since = since_inc;
                    if (since_inc > 2'd1) begin
                        if (anyout_reg && !out_free) begin
                            rwe = 1'b0;
                        end else if (rrdata.sends < retry_reg) begin
                            rwdata.since = 2'd0;
                            if (rrdata.sends != 8'hFF) rwdata.sends = rrdata.sends + 8'd1;
                        end
                    end
                end
                if (rwe || !rvalid_reg[ri_reg])
                    state_next = (ri_reg == RLAST) ? ST_FIN : ST_TRD;
            end
            ST_OUT: if (out_free) state_next = ST_IDLE;
            ST_FIN: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        // queue write-back of the chosen slot
        if (state_reg == ST_QWR) begin
            rwaddr = rslot_reg;
            rwe = rfound_reg;
            rwdata = rrdata;
            if (!rvalid_reg[rslot_reg]) begin
                rwdata.ip = ip_reg; rwdata.sends = 8'd0;
                rwdata.since = 2'd2; rwdata.pkts = 8'd0;
            end
            if (pkt_reg && rwdata.pkts != 8'hFF) rwdata.pkts = rwdata.pkts + 8'd1;
        end
        // insert write of the new entry in the output step
        if (state_reg == ST_OUT && act_reg == arpc_pkg::ACT_INSERT && out_free) begin
            ewe = efree_any;
            ewaddr = efree_idx;
            ewdata = '{ip: ip_reg, mac: mac_reg, age: 16'd0};
        end
    end

    // overdue request found; the previously held beat moves to the output, as does the final beat in ST_FIN and ST_OUT
    logic tick_due;
    logic out_load;
    assign tick_due = (state_reg == ST_TWR) && rwe && (since_inc > 2'd1);
    assign out_load = (tick_due && anyout_reg) ||
                      (state_reg == ST_FIN && out_free) ||
                      (state_reg == ST_OUT && out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            timeout_reg <= 16'd15;
            retry_reg  <= 8'd5;
            evalid_reg <= '0;
            rvalid_reg <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_addr == arpc_pkg::REG_TIMEOUT) timeout_reg <= cfg_wdata;
                else retry_reg <= cfg_wdata[7:0];
            end
            if (out_load) ovalid_reg <= 1'b1;
            else if (m_tready) ovalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        act_reg <= s_tuser;
                        ip_reg  <= s_tdata[31:0];
                        mac_reg <= s_tdata[79:32];
                        pkt_reg <= s_tdata[80];
                        ci_reg <= '0; ri_reg <= '0;
                        hit_reg <= 1'b0; hmac_reg <= '0;
                        rfound_reg <= 1'b0; rpkts_reg <= '0;
                        anyout_reg <= 1'b0;
                    end
                end
                ST_WREQ: begin
                    if (rvalid_reg[ri_reg] && rrdata.ip == ip_reg) begin
                        rfound_reg <= 1'b1;
                        rslot_reg <= ri_reg;
                        rpkts_reg <= rrdata.pkts;
                    end else if (ri_reg == RLAST && act_reg == arpc_pkg::ACT_QUEUE) begin
                        rfound_reg <= rfree_any;
                        rslot_reg <= rfree_idx;
                    end
                    ri_reg <= ri_reg + RW'(1);
                end
                ST_WENT: begin
                    if (act_reg == arpc_pkg::ACT_LOOKUP && evalid_reg[ci_reg] &&
                        erdata.ip == ip_reg) begin
                        hit_reg <= 1'b1;
                        hmac_reg <= erdata.mac;
                    end
                    if (act_reg == arpc_pkg::ACT_TICK && evalid_reg[ci_reg] &&
                        age_inc > timeout_reg)
                        evalid_reg[ci_reg] <= 1'b0;
                    ci_reg <= ci_reg + CW'(1);
                end
                ST_QWR: begin
                    if (rfound_reg) rvalid_reg[rslot_reg] <= 1'b1;
                    rpkts_reg <= rwdata.pkts;
                end
                ST_TWR: begin
                    // hold the new beat, push out the one held before
                    if (tick_due) begin
                        anyout_reg <= 1'b1;
                        hip_reg    <= rrdata.ip;
                        hpkts_reg  <= rrdata.pkts;
                        if (rrdata.sends >= retry_reg) begin
                            rvalid_reg[ri_reg] <= 1'b0;
                            hkind_reg <= arpc_pkg::KIND_UNRCH;
                        end else begin
                            hkind_reg <= arpc_pkg::KIND_SEND;
                        end
                        if (anyout_reg) begin
                            olast_reg <= 1'b0;
                            ouser_reg <= hkind_reg;
                            odata_reg <= pack_out(hip_reg, '0, 1'b0, hpkts_reg, 1'b0);
                        end
                    end
                    if (rwe || !rvalid_reg[ri_reg]) ri_reg <= ri_reg + RW'(1);
                end
                ST_FIN: begin
                    // final beat of the tick: the held one, else idle
                    if (out_free) begin
                        olast_reg <= 1'b1;
                        if (anyout_reg) begin
                            ouser_reg <= hkind_reg;
                            odata_reg <= pack_out(hip_reg, '0, 1'b0, hpkts_reg, 1'b0);
                        end else begin
                            ouser_reg <= arpc_pkg::KIND_IDLE;
                            odata_reg <= pack_out('0, '0, 1'b0, 8'd0, 1'b0);
                        end
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        olast_reg <= 1'b1;
                        case (act_reg)
                            arpc_pkg::ACT_LOOKUP: begin
                                ouser_reg <= arpc_pkg::KIND_LOOKUP;
                                odata_reg <= pack_out(ip_reg, hmac_reg, hit_reg,
                                                      8'd0, 1'b0);
                            end
                            arpc_pkg::ACT_INSERT: begin
                                ouser_reg <= arpc_pkg::KIND_INSERT;
                                odata_reg <= pack_out(ip_reg, '0, rfound_reg,
                                                      rpkts_reg, !efree_any);
                                if (rfound_reg) rvalid_reg[rslot_reg] <= 1'b0;
                                if (efree_any) evalid_reg[efree_idx] <= 1'b1;
                            end
                            default: begin
                                ouser_reg <= arpc_pkg::KIND_QUEUED;
                                odata_reg <= pack_out(ip_reg, '0, 1'b0,
                                    rfound_reg ? rpkts_reg : 8'd0, !rfound_reg);
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // hold a stalled result beat steady
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
        $stable(m_tuser) && $stable(m_tlast));

    // result kinds stay in the defined range
    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= arpc_pkg::KIND_IDLE);

    // state code stays legal
    a_state_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg <= ST_FIN);

    // reset drops the output beat
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid);
endmodule

FILE: rtl/arpc_ram.sv
// ----------------------------------------------------------------------------
// arpc_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// ARP cache with request retry testbench
// Drives lookup, insert, queue and tick beats through the stream ports and
// checks every result beat against an in-bench model of the cache and the
// pending-request table. Runs four random phases under three idling settings,
// with register changes between them.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NENT  = 16;
    localparam int NSLOT = 8;
    localparam int LIMIT = 900000;

    typedef struct packed {
        logic        pad_last;
        logic        full_res;
        logic [7:0]  pkts;
        logic        found;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [2:0]  kind;
    } arp_result_t;

    // cache and request-table model with a queue of expected result beats
    class arp_scoreboard;
        logic [15:0] timeout;
        logic [7:0]  retry_lim;
        bit          ev[NENT];
        logic [31:0] eip[NENT];
        logic [47:0] emac[NENT];
        logic [15:0] eage[NENT];
        bit          rv[NSLOT];
        logic [31:0] rip[NSLOT];
        logic [7:0]  rsends[NSLOT];
        logic [1:0]  rsince[NSLOT];
        logic [7:0]  rpk[NSLOT];
        arp_result_t pending[$];
        int          errors;

        function new();
            timeout = 16'd15;
            retry_lim = 8'd5;
            errors = 0;
            foreach (ev[i]) ev[i] = 1'b0;
            foreach (rv[i]) rv[i] = 1'b0;
        endfunction

        function void emit(logic [2:0] k, logic [31:0] ip, logic [47:0] mac,
                           logic f, logic [7:0] p, logic fl, logic l);
            arp_result_t r;
            r.kind = k; r.ip = ip; r.mac = mac; r.found = f;
            r.pkts = p; r.full_res = fl; r.pad_last = l;
            pending.push_back(r);
        endfunction

        function int find_slot(logic [31:0] ip);
            for (int s = 0; s < NSLOT; s++)
                if (rv[s] && rip[s] == ip) return s;
            return -1;
        endfunction

        function void note_input(logic [1:0] act, logic [31:0] ip,
                                 logic [47:0] mac, logic pkt);
            int s;
            int n;
            bit hit;
            logic [47:0] m;
            logic [7:0] p;
            bit fl;
            case (act)
                arpc_pkg::ACT_LOOKUP: begin
                    hit = 1'b0; m = '0;
                    for (int i = 0; i < NENT; i++)
                        if (ev[i] && eip[i] == ip) begin
                            hit = 1'b1; m = emac[i];
                        end
                    emit(arpc_pkg::KIND_LOOKUP, ip, m, hit, 8'd0, 1'b0, 1'b1);
                end
                arpc_pkg::ACT_INSERT: begin
                    hit = 1'b0; p = 8'd0; fl = 1'b1;
                    s = find_slot(ip);
                    if (s >= 0) begin
                        hit = 1'b1; p = rpk[s]; rv[s] = 1'b0;
                    end
                    for (int i = 0; i < NENT; i++)
                        if (!ev[i]) begin
                            ev[i] = 1'b1; eip[i] = ip; emac[i] = mac; eage[i] = 16'd0;
                            fl = 1'b0;
                            break;
                        end
                    emit(arpc_pkg::KIND_INSERT, ip, 48'd0, hit, p, fl, 1'b1);
                end
                arpc_pkg::ACT_QUEUE: begin
                    s = find_slot(ip);
                    if (s < 0)
                        for (int i = 0; i < NSLOT; i++)
                            if (!rv[i]) begin
                                s = i; rv[i] = 1'b1; rip[i] = ip; rsends[i] = 8'd0;
                                rsince[i] = 2'd2; rpk[i] = 8'd0;
                                break;
                            end
                    if (s < 0) begin
                        emit(arpc_pkg::KIND_QUEUED, ip, 48'd0, 1'b0, 8'd0, 1'b1, 1'b1);
                    end else begin
                        if (pkt && rpk[s] != 8'hFF) rpk[s]++;
                        emit(arpc_pkg::KIND_QUEUED, ip, 48'd0, 1'b0, rpk[s], 1'b0, 1'b1);
                    end
                end
                default: begin
                    for (int i = 0; i < NENT; i++) begin
                        if (!ev[i]) continue;
                        if (eage[i] != 16'hFFFF) eage[i]++;
                        if (eage[i] > timeout) ev[i] = 1'b0;
                    end
                    n = 0;
                    for (int i = 0; i < NSLOT; i++) begin
                        if (!rv[i]) continue;
                        if (rsince[i] != 2'd3) rsince[i]++;
                        if (rsince[i] <= 2'd1) continue;
                        if (rsends[i] >= retry_lim) begin
                            emit(arpc_pkg::KIND_UNRCH, rip[i], 48'd0, 1'b0, rpk[i],
                                 1'b0, 1'b0);
                            rv[i] = 1'b0;
                        end else begin
                            emit(arpc_pkg::KIND_SEND, rip[i], 48'd0, 1'b0, rpk[i],
                                 1'b0, 1'b0);
                            if (rsends[i] != 8'hFF) rsends[i]++;
                            rsince[i] = 2'd0;
                        end
                        n++;
                    end
                    if (n == 0)
                        emit(arpc_pkg::KIND_IDLE, 32'd0, 48'd0, 1'b0, 8'd0, 1'b0, 1'b1);
                    else
                        pending[$].pad_last = 1'b1;
                end
            endcase
        endfunction

        function void check_result(logic [95:0] d, logic [2:0] u, logic l);
            arp_result_t e;
            arp_result_t a;
            a = {l, d[89:0], u};
            if (pending.size() == 0) begin
                $display("%0t unexpected beat: expected none, actual %h kind %0d last %b",
                         $realtime, d, u, l);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[95:90] !== 6'b0) begin
                $display("%0t pad: expected 0, actual %h", $realtime, d[95:90]);
                errors++;
            end
            if (a.kind !== e.kind) begin
                $display("%0t kind: expected %0d, actual %0d", $realtime, e.kind, a.kind);
                errors++;
            end
            if (a.ip !== e.ip) begin
                $display("%0t ip: expected %h, actual %h", $realtime, e.ip, a.ip);
                errors++;
            end
            if (a.mac !== e.mac) begin
                $display("%0t mac: expected %h, actual %h", $realtime, e.mac, a.mac);
                errors++;
            end
            if (a.found !== e.found) begin
                $display("%0t found: expected %b, actual %b", $realtime, e.found, a.found);
                errors++;
            end
            if (a.pkts !== e.pkts) begin
                $display("%0t packets: expected %0d, actual %0d", $realtime, e.pkts, a.pkts);
                errors++;
            end
            if (a.full_res !== e.full_res) begin
                $display("%0t full: expected %b, actual %b", $realtime,
                         e.full_res, a.full_res);
                errors++;
            end
            if (a.pad_last !== e.pad_last) begin
                $display("%0t last: expected %b, actual %b", $realtime,
                         e.pad_last, a.pad_last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [2:0]  m_tuser;
    logic [95:0] m_tdata;
    logic        m_tlast;

    arp_scoreboard sb;
    int          send_idle;
    int          recv_idle;
    int          cycles;
    logic [31:0] ip_pool[8];

    arp_cache_with_request_retry_top uut (.*);

    initial begin
        aclk = 0;
    end
    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL arp_cache_with_request_retry_top");
            $finish;
        end
    end

    // result side: random stall, check each accepted beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // hold valid high from the first offered cycle until the accepting edge
    task automatic send_beat(logic [1:0] act, logic [31:0] ip, logic [47:0] mac,
                             logic pkt);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {7'b0, pkt, mac, ip};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(act, ip, mac, pkt);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == arpc_pkg::REG_TIMEOUT) sb.timeout = val;
        else sb.retry_lim = val[7:0];
        @(posedge aclk);
    endtask

    task automatic drain();
        int n;
        n = 0;
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        while (n < 80) begin
            @(posedge aclk);
            n++;
        end
    endtask

    // mostly well-formed traffic over a small address pool
    task automatic random_phase(int count);
        logic [1:0]  act;
        logic [31:0] ip;
        logic [47:0] mac;
        for (int k = 0; k < count; k++) begin
            act = 2'($urandom_range(3));
            ip = ($urandom_range(9) == 0) ? $urandom() : ip_pool[3'($urandom_range(7))];
            mac = 48'({$urandom(), $urandom()});
            send_beat(act, ip, mac, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        sb = new();
        cycles = 0;
        aresetn = 0;
        cfg_we = 0; cfg_addr = 0; cfg_wdata = '0;
        s_tvalid = 0; s_tuser = '0; s_tdata = '0;
        m_tready = 0;
        send_idle = 27; recv_idle = 67;
        foreach (ip_pool[i]) ip_pool[i] = $urandom();
        ip_pool[0] = 32'h0; ip_pool[1] = 32'hFFFF_FFFF;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // short timeout and retry so expiry and unreachable show up early
        write_reg(arpc_pkg::REG_TIMEOUT, 16'd1);
        write_reg(arpc_pkg::REG_RETRY, 16'd1);

        // directed: extremes, queue fill, table full, duplicates, retries
        send_beat(arpc_pkg::ACT_LOOKUP, 32'h0, 48'h0, 1'b0);
        send_beat(arpc_pkg::ACT_QUEUE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_beat(arpc_pkg::ACT_QUEUE, 32'hFFFF_FFFF, 48'h0, 1'b1);
        for (int i = 0; i < 8; i++)
            send_beat(arpc_pkg::ACT_QUEUE, 32'(32'h100 + i), 48'h0, i[0]);
        send_beat(arpc_pkg::ACT_TICK, 32'h0, 48'h0, 1'b0);
        send_beat(arpc_pkg::ACT_TICK, 32'h0, 48'h0, 1'b0);
        send_beat(arpc_pkg::ACT_TICK, 32'h0, 48'h0, 1'b0);
        send_beat(arpc_pkg::ACT_TICK, 32'h0, 48'h0, 1'b0);
        send_beat(arpc_pkg::ACT_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
        send_beat(arpc_pkg::ACT_INSERT, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 1'b0);
        send_beat(arpc_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b1);
        for (int i = 0; i < 15; i++)
            send_beat(arpc_pkg::ACT_INSERT, 32'(32'h200 + i), {16'h0, $urandom()}, 1'b0);
        send_beat(arpc_pkg::ACT_LOOKUP, 32'h20D, 48'h0, 1'b0);
        send_beat(arpc_pkg::ACT_TICK, 32'h0, 48'h0, 1'b0);
        send_beat(arpc_pkg::ACT_TICK, 32'h0, 48'h0, 1'b0);
        send_beat(arpc_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b0);
        drain();

        random_phase(90);
        drain();
        write_reg(arpc_pkg::REG_TIMEOUT, 16'hFFFF);
        write_reg(arpc_pkg::REG_RETRY, 16'd255);
        send_idle = 67; recv_idle = 27;
        random_phase(90);
        drain();
        write_reg(arpc_pkg::REG_TIMEOUT, 16'd0);
        write_reg(arpc_pkg::REG_RETRY, 16'd0);
        random_phase(20);
        drain();
        write_reg(arpc_pkg::REG_TIMEOUT, 16'd4);
        write_reg(arpc_pkg::REG_RETRY, 16'd3);
        send_idle = 0; recv_idle = 0;
        random_phase(75);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS arp_cache_with_request_retry_top");
        end else begin
            $display("FAIL arp_cache_with_request_retry_top");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/arpc_pkg.sv
rtl/arpc_ram.sv
rtl/arp_cache_with_request_retry_top.sv
verif/testbench.sv
